FILE: rtl/core/segint_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection test: shared types and constants
// Coordinate and product widths, queue sizing and the classified pair that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package segint_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   // queue depth must be a power of two so the pointers wrap on their own
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;

   // a = first start, b = first end, c = second start, d = second end
   typedef struct packed {
      logic     box_hit;
      diff_type ab_x;
      diff_type ab_y;
      diff_type ac_x;
      diff_type ac_y;
      diff_type ad_x;
      diff_type ad_y;
      diff_type cd_x;
      diff_type cd_y;
      diff_type ca_x;
      diff_type ca_y;
      diff_type cb_x;
      diff_type cb_y;
   } pair_type;

endpackage
`default_nettype wire

FILE: rtl/core/segint_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection front end
// Takes request beats, runs the bounding-box test and forms the coordinate
// differences that the cross products need.
// ----------------------------------------------------------------------------
module segint_front (
   input  wire                   req_push,
   output logic                  req_full,
   input  segint_pkg::coord_type ax,
   input  segint_pkg::coord_type ay,
   input  segint_pkg::coord_type bx,
   input  segint_pkg::coord_type by,
   input  segint_pkg::coord_type cx,
   input  segint_pkg::coord_type cy,
   input  segint_pkg::coord_type dx,
   input  segint_pkg::coord_type dy,
   input  wire                   mid_full,
   output logic                  mid_push,
   output segint_pkg::pair_type  mid_pair
);

   segint_pkg::coord_type ab_x_lo, ab_x_hi, ab_y_lo, ab_y_hi;
   segint_pkg::coord_type cd_x_lo, cd_x_hi, cd_y_lo, cd_y_hi;

   assign req_full = mid_full;
   assign mid_push = req_push;

   always_comb begin
      ab_x_lo = (ax < bx) ? ax : bx;
      ab_x_hi = (ax > bx) ? ax : bx;
      ab_y_lo = (ay < by) ? ay : by;
      ab_y_hi = (ay > by) ? ay : by;
      cd_x_lo = (cx < dx) ? cx : dx;
      cd_x_hi = (cx > dx) ? cx : dx;
      cd_y_lo = (cy < dy) ? cy : dy;
      cd_y_hi = (cy > dy) ? cy : dy;
   end

   always_comb begin
      // touching boxes count as overlapping
      mid_pair.box_hit = (ab_x_hi >= cd_x_lo) && (cd_x_hi >= ab_x_lo) &&
                         (ab_y_hi >= cd_y_lo) && (cd_y_hi >= ab_y_lo);
      mid_pair.ab_x = segint_pkg::DIFF_BITS'(bx) - segint_pkg::DIFF_BITS'(ax);
      mid_pair.ab_y = segint_pkg::DIFF_BITS'(by) - segint_pkg::DIFF_BITS'(ay);
      mid_pair.ac_x = segint_pkg::DIFF_BITS'(cx) - segint_pkg::DIFF_BITS'(ax);
      mid_pair.ac_y = segint_pkg::DIFF_BITS'(cy) - segint_pkg::DIFF_BITS'(ay);
      mid_pair.ad_x = segint_pkg::DIFF_BITS'(dx) - segint_pkg::DIFF_BITS'(ax);
      mid_pair.ad_y = segint_pkg::DIFF_BITS'(dy) - segint_pkg::DIFF_BITS'(ay);
      mid_pair.cd_x = segint_pkg::DIFF_BITS'(dx) - segint_pkg::DIFF_BITS'(cx);
      mid_pair.cd_y = segint_pkg::DIFF_BITS'(dy) - segint_pkg::DIFF_BITS'(cy);
      mid_pair.ca_x = segint_pkg::DIFF_BITS'(ax) - segint_pkg::DIFF_BITS'(cx);
      mid_pair.ca_y = segint_pkg::DIFF_BITS'(ay) - segint_pkg::DIFF_BITS'(cy);
      mid_pair.cb_x = segint_pkg::DIFF_BITS'(bx) - segint_pkg::DIFF_BITS'(cx);
      mid_pair.cb_y = segint_pkg::DIFF_BITS'(by) - segint_pkg::DIFF_BITS'(cy);
   end

endmodule
`default_nettype wire

FILE: rtl/core/segint_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection pair queue
// Short queue of classified pairs between the front end and the back end.
// ----------------------------------------------------------------------------
module segint_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  segint_pkg::pair_type push_data,
   output logic                 full,
   input  wire                  pop,
   output segint_pkg::pair_type pop_data,
   output logic                 empty
);

   segint_pkg::pair_type                 entry_ff [segint_pkg::Q_DEPTH];
   logic [segint_pkg::Q_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [segint_pkg::Q_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [segint_pkg::Q_CNT_BITS-1:0]    count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full     = (count_ff == segint_pkg::Q_CNT_BITS'(segint_pkg::Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/segint_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection back end
// Two-stage pipeline: the eight exact products, then the four cross
// products, their signs and the straddle decision.
// ----------------------------------------------------------------------------
module segint_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  mid_empty,
   input  segint_pkg::pair_type mid_pair,
   output logic                 mid_pop,
   input  wire                  rsp_full,
   output logic                 rsp_push,
   output logic                 rsp_hit
);

   localparam int PRODUCTS = 8;
   localparam int CROSSES  = PRODUCTS / 2;

   logic                                  advance;
   logic signed [segint_pkg::PROD_BITS-1:0]  prod_in [PRODUCTS];
   logic signed [segint_pkg::PROD_BITS-1:0]  prod_ff [PRODUCTS];
   logic signed [segint_pkg::CROSS_BITS-1:0] cross_val [CROSSES];
   logic [CROSSES-1:0]                    pos, neg;
   logic                                  s1_valid_ff, s1_box_ff;
   logic                                  s2_valid_ff, s2_hit_ff, s2_hit_in;
   segint_pkg::diff_type ab_x, ab_y, ac_x, ac_y, ad_x, ad_y;
   segint_pkg::diff_type cd_x, cd_y, ca_x, ca_y, cb_x, cb_y;

   // hold the whole pipe only while a finished beat cannot leave
   assign advance  = !(s2_valid_ff && rsp_full);
   assign mid_pop  = advance && !mid_empty;
   assign rsp_push = s2_valid_ff && !rsp_full;
   assign rsp_hit  = s2_hit_ff;

   always_comb begin
      ab_x = mid_pair.ab_x;
      ab_y = mid_pair.ab_y;
      ac_x = mid_pair.ac_x;
      ac_y = mid_pair.ac_y;
      ad_x = mid_pair.ad_x;
      ad_y = mid_pair.ad_y;
      cd_x = mid_pair.cd_x;
      cd_y = mid_pair.cd_y;
      ca_x = mid_pair.ca_x;
      ca_y = mid_pair.ca_y;
      cb_x = mid_pair.cb_x;
      cb_y = mid_pair.cb_y;
      prod_in[0] = segint_pkg::PROD_BITS'(ac_x) * segint_pkg::PROD_BITS'(ab_y);
      prod_in[1] = segint_pkg::PROD_BITS'(ac_y) * segint_pkg::PROD_BITS'(ab_x);
      prod_in[2] = segint_pkg::PROD_BITS'(ad_x) * segint_pkg::PROD_BITS'(ab_y);
      prod_in[3] = segint_pkg::PROD_BITS'(ad_y) * segint_pkg::PROD_BITS'(ab_x);
      prod_in[4] = segint_pkg::PROD_BITS'(ca_x) * segint_pkg::PROD_BITS'(cd_y);
      prod_in[5] = segint_pkg::PROD_BITS'(ca_y) * segint_pkg::PROD_BITS'(cd_x);
      prod_in[6] = segint_pkg::PROD_BITS'(cb_x) * segint_pkg::PROD_BITS'(cd_y);
      prod_in[7] = segint_pkg::PROD_BITS'(cb_y) * segint_pkg::PROD_BITS'(cd_x);
   end

   always_comb begin
      for (int i = 0; i < CROSSES; i++) begin
         cross_val[i] = segint_pkg::CROSS_BITS'(prod_ff[2*i]) -
                        segint_pkg::CROSS_BITS'(prod_ff[2*i+1]);
         pos[i]       = (cross_val[i] > 0);
         neg[i]       = (cross_val[i] < 0);
      end
      // a zero cross product counts as touching
      s2_hit_in = s1_box_ff &&
                  !((pos[0] && pos[1]) || (neg[0] && neg[1])) &&
                  !((pos[2] && pos[3]) || (neg[2] && neg[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= mid_pop;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_box_ff <= mid_pair.box_hit;
         s2_hit_ff <= s2_hit_in;
         for (int i = 0; i < PRODUCTS; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/segint_rsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection response queue
// Short queue of result beats that parts the back end from the consumer.
// ----------------------------------------------------------------------------
module segint_rsp_queue (
   input  wire  clock,
   input  wire  reset,
   input  wire  push,
   input  wire  push_hit,
   output logic full,
   input  wire  pop,
   output logic pop_hit,
   output logic empty
);

   logic [segint_pkg::Q_DEPTH-1:0]    hit_ff;
   logic [segint_pkg::Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [segint_pkg::Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [segint_pkg::Q_CNT_BITS-1:0] count_ff, count_in;
   logic                              do_push, do_pop;

   assign full    = (count_ff == segint_pkg::Q_CNT_BITS'(segint_pkg::Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_hit = hit_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         hit_ff[wr_ptr_ff] <= push_hit;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/segment_intersection_test_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection test
// Reports whether two 2-D segments touch or cross, using a bounding-box test
// and four exact cross products.
// ----------------------------------------------------------------------------
// Each request beat carries the end points of two segments as signed 16-bit
// coordinates; each one gives exactly one response beat, in order, with
// rsp_intersects set when the segments touch or cross. The block takes one
// beat per cycle while req_full is low. An accepted request passes from the
// front end into a two-entry pair queue, then through the two-stage multiply
// and sign pipeline of the back end into the response queue. Both sides stall
// on their own: a full response queue holds the back end, and req_full rises
// only when the pair queue fills.
module segment_intersection_test_top (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  segint_pkg::coord_type req_first_start_x,
   input  segint_pkg::coord_type req_first_start_y,
   input  segint_pkg::coord_type req_first_end_x,
   input  segint_pkg::coord_type req_first_end_y,
   input  segint_pkg::coord_type req_second_start_x,
   input  segint_pkg::coord_type req_second_start_y,
   input  segint_pkg::coord_type req_second_end_x,
   input  segint_pkg::coord_type req_second_end_y,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output logic                  rsp_intersects
);

   logic                 mid_push, mid_full, mid_pop, mid_empty;
   segint_pkg::pair_type front_pair, back_pair;
   logic                 back_push, back_hit, back_full;

   segint_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .ax       (req_first_start_x),
      .ay       (req_first_start_y),
      .bx       (req_first_end_x),
      .by       (req_first_end_y),
      .cx       (req_second_start_x),
      .cy       (req_second_start_y),
      .dx       (req_second_end_x),
      .dy       (req_second_end_y),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_pair (front_pair)
   );

   segint_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_pair),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (back_pair),
      .empty     (mid_empty)
   );

   segint_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pair  (back_pair),
      .mid_pop   (mid_pop),
      .rsp_full  (back_full),
      .rsp_push  (back_push),
      .rsp_hit   (back_hit)
   );

   segint_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (back_push),
      .push_hit (back_hit),
      .full     (back_full),
      .pop      (rsp_pop),
      .pop_hit  (rsp_intersects),
      .empty    (rsp_empty)
   );

   // back end never drops a finished beat into a full response queue
   assert property (@(posedge clock) disable iff (reset) back_push |-> !back_full)
      else $error("result beat pushed into full response queue");

   // back end never pops an empty pair queue
   assert property (@(posedge clock) disable iff (reset) mid_pop |-> !mid_empty)
      else $error("pair queue popped while empty");

   // both queues come out of reset empty and ready
   assert property (@(posedge clock) disable iff (reset)
                    $past(reset) |-> (!req_full && rsp_empty && mid_empty))
      else $error("queues not cleared by reset");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test: testbench
// Drives segment pairs through the request port with random push and pop
// gaps. An independent predictor (box overlap plus four exact cross-product
// signs) works out each response, and the monitor checks responses in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PAIRS = 400;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      segint_pkg::coord_type first_start_x;
      segint_pkg::coord_type first_start_y;
      segint_pkg::coord_type first_end_x;
      segint_pkg::coord_type first_end_y;
      segint_pkg::coord_type second_start_x;
      segint_pkg::coord_type second_start_y;
      segint_pkg::coord_type second_end_x;
      segint_pkg::coord_type second_end_y;
   } seg_pair_type;

   typedef struct {
      seg_pair_type pair;
      bit           drain_first;
   } pending_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   segint_pkg::coord_type req_first_start_x = '0;
   segint_pkg::coord_type req_first_start_y = '0;
   segint_pkg::coord_type req_first_end_x = '0;
   segint_pkg::coord_type req_first_end_y = '0;
   segint_pkg::coord_type req_second_start_x = '0;
   segint_pkg::coord_type req_second_start_y = '0;
   segint_pkg::coord_type req_second_end_x = '0;
   segint_pkg::coord_type req_second_end_y = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_intersects;

   pending_pair_type pending_pairs[$];
   bit               expected_hits[$];
   bit               wanted_hit;
   int               total_pairs = 1;
   int               sent_count = 0;
   int               got_count = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   segment_intersection_test_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_first_start_x (req_first_start_x),
      .req_first_start_y (req_first_start_y),
      .req_first_end_x   (req_first_end_x),
      .req_first_end_y   (req_first_end_y),
      .req_second_start_x(req_second_start_x),
      .req_second_start_y(req_second_start_y),
      .req_second_end_x  (req_second_end_x),
      .req_second_end_y  (req_second_end_y),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_intersects    (rsp_intersects)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // sign of (q - o) x (t - o)
   function automatic int turn_sign(longint ox, longint oy, longint tx, longint ty,
                                    longint qx, longint qy);
      longint z;
      z = (qx - ox) * (ty - oy) - (qy - oy) * (tx - ox);
      return (z > 0) ? 1 : ((z < 0) ? -1 : 0);
   endfunction

   function automatic bit spans_overlap(longint a0, longint a1, longint b0, longint b1);
      longint a_lo, a_hi, b_lo, b_hi;
      a_lo = (a0 < a1) ? a0 : a1;
      a_hi = (a0 > a1) ? a0 : a1;
      b_lo = (b0 < b1) ? b0 : b1;
      b_hi = (b0 > b1) ? b0 : b1;
      return (a_hi >= b_lo) && (b_hi >= a_lo);
   endfunction

   function automatic bit segments_meet(seg_pair_type p);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      int     c_side, d_side, a_side, b_side;
      ax = p.first_start_x;
      ay = p.first_start_y;
      bx = p.first_end_x;
      by = p.first_end_y;
      cx = p.second_start_x;
      cy = p.second_start_y;
      dx = p.second_end_x;
      dy = p.second_end_y;
      if (!spans_overlap(ax, bx, cx, dx) || !spans_overlap(ay, by, cy, dy)) begin
         return 1'b0;
      end
      c_side = turn_sign(ax, ay, bx, by, cx, cy);
      d_side = turn_sign(ax, ay, bx, by, dx, dy);
      a_side = turn_sign(cx, cy, dx, dy, ax, ay);
      b_side = turn_sign(cx, cy, dx, dy, bx, by);
      return (c_side * d_side <= 0) && (a_side * b_side <= 0);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic seg_pair_type make_pair(int ax, int ay, int bx, int by,
                                              int cx, int cy, int dx, int dy);
      seg_pair_type p;
      p.first_start_x  = segint_pkg::coord_type'(ax);
      p.first_start_y  = segint_pkg::coord_type'(ay);
      p.first_end_x    = segint_pkg::coord_type'(bx);
      p.first_end_y    = segint_pkg::coord_type'(by);
      p.second_start_x = segint_pkg::coord_type'(cx);
      p.second_start_y = segint_pkg::coord_type'(cy);
      p.second_end_x   = segint_pkg::coord_type'(dx);
      p.second_end_y   = segint_pkg::coord_type'(dy);
      return p;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int near(int c, int r);
      return c + int'($urandom_range(2 * r)) - r;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return any_coord();
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      int           ox, oy, ux, uy, m, k, tx, ty, cx, cy;
      int           k0, k1, k2, k3;
      seg_pair_type p;
      ox = int'($urandom_range(64000)) - 32000;
      oy = int'($urandom_range(64000)) - 32000;
      ux = int'($urandom_range(8)) - 4;
      uy = int'($urandom_range(8)) - 4;
      case ($urandom_range(9))
         0, 1: begin
            p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord());
         end
         2, 3, 9: begin
            p = make_pair(near(ox, 6), near(oy, 6), near(ox, 6), near(oy, 6),
                          near(ox, 6), near(oy, 6), near(ox, 6), near(oy, 6));
         end
         4: begin
            // four points on one line through the origin point
            k0 = int'($urandom_range(8)) - 4;
            k1 = int'($urandom_range(8)) - 4;
            k2 = int'($urandom_range(8)) - 4;
            k3 = int'($urandom_range(8)) - 4;
            p = make_pair(ox + k0 * ux, oy + k0 * uy, ox + k1 * ux, oy + k1 * uy,
                          ox + k2 * ux, oy + k2 * uy, ox + k3 * ux, oy + k3 * uy);
         end
         5, 6: begin
            // one end of one segment lands on the other segment
            m  = int'($urandom_range(1, 5));
            k  = int'($urandom_range(m));
            tx = ox + k * ux;
            ty = oy + k * uy;
            cx = near(ox, 12);
            cy = near(oy, 12);
            if ($urandom_range(1)) begin
               p = make_pair(ox, oy, ox + m * ux, oy + m * uy, cx, cy, tx, ty);
            end else begin
               p = make_pair(ox, oy, ox + m * ux, oy + m * uy, tx, ty, cx, cy);
            end
            if ($urandom_range(1)) begin
               p = make_pair(p.second_start_x, p.second_start_y, p.second_end_x,
                             p.second_end_y, p.first_start_x, p.first_start_y,
                             p.first_end_x, p.first_end_y);
            end
         end
         7: begin
            p = make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                          extreme_coord(), extreme_coord(), extreme_coord(),
                          extreme_coord(), extreme_coord());
         end
         default: begin
            // point segment against a short segment nearby
            tx = near(ox, 4);
            ty = near(oy, 4);
            if ($urandom_range(1)) begin
               p = make_pair(tx, ty, tx, ty, near(ox, 6), near(oy, 6),
                             near(ox, 6), near(oy, 6));
            end else begin
               p = make_pair(near(ox, 6), near(oy, 6), near(ox, 6), near(oy, 6),
                             tx, ty, tx, ty);
            end
         end
      endcase
      return p;
   endfunction

   task automatic queue_pair(input seg_pair_type p, input bit drain_first);
      pending_pair_type e;
      e.pair = p;
      e.drain_first = drain_first;
      pending_pairs.push_back(e);
   endtask

   // idle rates per third of the run: sender light first, then receiver light, then no idling
   function automatic int idle_pct(int done, bit sender);
      if (done < total_pairs / 3) begin
         return sender ? 20 : 71;
      end else if (done < 2 * total_pairs / 3) begin
         return sender ? 71 : 20;
      end
      return 0;
   endfunction

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_hits.push_back(segments_meet(pending_pairs[0].pair));
            void'(pending_pairs.pop_front());
            sent_count++;
         end
         // hold a beat that was refused
         if (!(req_push && req_full)) begin
            if (pending_pairs.size() != 0 &&
                $urandom_range(99) >= idle_pct(sent_count, 1'b1) &&
                !(pending_pairs[0].drain_first && expected_hits.size() != 0)) begin
               req_first_start_x  <= pending_pairs[0].pair.first_start_x;
               req_first_start_y  <= pending_pairs[0].pair.first_start_y;
               req_first_end_x    <= pending_pairs[0].pair.first_end_x;
               req_first_end_y    <= pending_pairs[0].pair.first_end_y;
               req_second_start_x <= pending_pairs[0].pair.second_start_x;
               req_second_start_y <= pending_pairs[0].pair.second_start_y;
               req_second_end_x   <= pending_pairs[0].pair.second_end_x;
               req_second_end_y   <= pending_pairs[0].pair.second_end_y;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_hits.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected response beat: intersects=%b", rsp_intersects);
               end
            end else begin
               wanted_hit = expected_hits.pop_front();
               if (rsp_intersects !== wanted_hit) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("response %0d: intersects expected %b, got %b",
                              got_count, wanted_hit, rsp_intersects);
                  end
               end
            end
            got_count++;
         end
         rsp_pop <= ($urandom_range(99) >= idle_pct(got_count, 1'b0));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      // crossing, parallel, touching and shared end points
      queue_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0), 1'b0);
      queue_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1), 1'b0);
      queue_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 10), 1'b0);
      queue_pair(make_pair(0, 0, 5, 5, 5, 5, 10, 0), 1'b0);
      // collinear: overlapping, apart, end to end
      queue_pair(make_pair(0, 0, 10, 0, 5, 0, 20, 0), 1'b0);
      queue_pair(make_pair(0, 0, 4, 4, 6, 6, 9, 9), 1'b0);
      queue_pair(make_pair(0, 0, 4, 4, 4, 4, 9, 9), 1'b0);
      // segments that miss: boxes overlap in the first two, not in the last
      queue_pair(make_pair(0, 0, 10, 10, 0, 3, 3, 10), 1'b0);
      queue_pair(make_pair(0, 0, 10, 10, 9, 0, 20, 1), 1'b0);
      queue_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10), 1'b0);
      // point segments
      queue_pair(make_pair(0, 0, 10, 10, 5, 5, 5, 5), 1'b0);
      queue_pair(make_pair(0, 0, 10, 10, 5, 6, 5, 6), 1'b0);
      queue_pair(make_pair(7, -7, 7, -7, 7, -7, 7, -7), 1'b0);
      queue_pair(make_pair(7, -7, 7, -7, 7, -6, 7, -6), 1'b0);
      // full-scale coordinates
      queue_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
                 1'b0);
      queue_pair(make_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767),
                 1'b0);
      queue_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767), 1'b0);
      queue_pair(make_pair(-32768, 32767, 32767, -32767, 32767, 32767, 32766, -32768),
                 1'b0);
      queue_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           -32768), 1'b0);
      queue_pair(make_pair(32767, 32767, 32767, 32767, -1, -1, 32767, 32767), 1'b0);
      queue_pair(make_pair(-5, -5, -1, -1, -5, -1, -1, -5), 1'b0);
      queue_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0), 1'b0);
      total_pairs = pending_pairs.size() + RANDOM_PAIRS;
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         // drain the pipeline at the start of random traffic and at phase changes
         queue_pair(random_pair(), n == 0 || n == total_pairs / 3 - 22 ||
                                   n == 2 * total_pairs / 3 - 22);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_push || expected_hits.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: segment_intersection_test_top.f
rtl/core/segint_pkg.sv
rtl/core/segint_front.sv
rtl/core/segint_queue.sv
rtl/core/segint_back.sv
rtl/core/segint_rsp_queue.sv
rtl/core/segment_intersection_test_top.sv
test/testbench.sv
